>>> src/isotope_scatter_accumulate_core_macros.svh
// Assertion macros used by the scatter-accumulate core.
`ifndef ISOTOPE_SCATTER_ACCUMULATE_CORE_MACROS_SVH
`define ISOTOPE_SCATTER_ACCUMULATE_CORE_MACROS_SVH
`ifndef SYNTH
`define ISC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isc: same-cycle check failed");
`define ISC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isc: next-cycle check failed");
`else
`define ISC_ASSERT_NOW(label, clk, rst, ante, cons)
`define ISC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/isc_pkg.sv
`timescale 1ns / 1ps
package isc_pkg;

   localparam int MZ_BINS_DEF = 1024;
   localparam int CHARGES_DEF = 32;

   localparam int INT_W      = 24;
   localparam int WGT_W      = 17;
   localparam int PROD_W     = INT_W + WGT_W;
   localparam int FRAC_BITS  = 16;
   localparam int MZ_W       = 10;
   localparam int CH_W       = 5;
   localparam int ACC_W      = 40;
   localparam int CNT_W      = 16;
   localparam int MZ_LEN_W   = 11;
   localparam int CHG_LEN_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [ACC_W-1:0] ACC_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic REQ_CONTRIBUTE = 1'b0;
   localparam logic REQ_READ       = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MZ_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGES = 2'd1;

   localparam logic [MZ_LEN_W-1:0]  MZ_LEN_RESET  = 11'd1024;
   localparam logic [CHG_LEN_W-1:0] CHARGES_RESET = 6'd32;

   typedef struct packed {
      logic [ACC_W-1:0] sum_value;
      logic [CNT_W-1:0] dropped_count;
      logic [CNT_W-1:0] peaks_done;
   } rsp_item_type;

endpackage

>>> src/isc_req_if.sv
`timescale 1ns / 1ps
interface isc_req_if
   import isc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic             source_enabled;
   logic [INT_W-1:0] intensity;
   logic [WGT_W-1:0] weight;
   logic [MZ_W-1:0]  target_mz_index;
   logic [CH_W-1:0]  charge_index;
   logic             last_of_run;

   modport source (
      output valid, req_type, source_enabled, intensity, weight,
             target_mz_index, charge_index, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, req_type, source_enabled, intensity, weight,
             target_mz_index, charge_index, last_of_run,
      output ready
   );
endinterface

>>> src/isc_rsp_if.sv
`timescale 1ns / 1ps
interface isc_rsp_if
   import isc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ACC_W-1:0] sum_value;
   logic [CNT_W-1:0] dropped_count;
   logic [CNT_W-1:0] peaks_done;

   modport source (
      output valid, sum_value, dropped_count, peaks_done,
      input  ready
   );
   modport sink (
      input  valid, sum_value, dropped_count, peaks_done,
      output ready
   );
endinterface

>>> src/isc_acc_mem.sv
`timescale 1ns / 1ps
module isc_acc_mem
   import isc_pkg::*;
#(
   parameter int DEPTH = MZ_BINS_DEF * CHARGES_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [ACC_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [ACC_W-1:0] wr_data,
   output logic             busy
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [ACC_W-1:0] acc_mem [DEPTH];
   logic [ACC_W-1:0] rd_data_ff;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic             busy_ff, busy_in;
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [ACC_W-1:0] mem_wd;

   // After reset every entry is swept to zero, one per cycle.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         busy_ff     <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         busy_ff     <= busy_in;
      end
   end

   assign mem_we = busy_ff || wr_en;
   assign mem_wa = busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wd = busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= acc_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

>>> src/isc_rsp_fifo.sv
`timescale 1ns / 1ps
module isc_rsp_fifo
   import isc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_data,
   input  logic         pop,
   output logic         valid,
   output rsp_item_type head,
   output logic [1:0]   count
);

   rsp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign valid = (count_ff != 2'd0);
   assign head  = slot_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

>>> src/isotope_scatter_accumulate_core.sv
`timescale 1ns / 1ps
// Weighted scatter-accumulate of isotope intensities into an on-chip store.
// The req channel carries one transaction per isotope entry: a contribute
// transaction adds floor(intensity * weight / 2^16) into the entry at
// (target_mz_index, charge_index), saturating at 2^40-1, and a read
// transaction returns that entry and clears it. Only reads produce an rsp
// transaction, which also reports the dropped and completed-peak counters.
// The csr port sets the bins and charge states in use; write it only while
// the block is idle.
// One transaction is accepted per cycle, back to back, while req ready is high,
// using the separate read and write ports of the accumulator memory; a forwarding
// register covers repeated hits on the same entry. A read result passes through
// the stage-1 register and the result buffer before it appears on rsp.
// After reset the MZ_BINS * CHARGES memory entries (32768 by default) are
// cleared one entry per cycle, while req ready stays low.
// Results wait in a two-entry buffer; when the receiver stalls and the buffer
// would overflow, req ready drops until rsp transactions drain.
`include "isotope_scatter_accumulate_core_macros.svh"
module isotope_scatter_accumulate_core
   import isc_pkg::*;
#(
   parameter int MZ_BINS = MZ_BINS_DEF,
   parameter int CHARGES = CHARGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   isc_req_if.sink               req_ch,
   isc_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = MZ_BINS * CHARGES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [16:0] MZ_BINS_LIM = 17'(MZ_BINS);
   localparam logic [8:0]  CHARGES_LIM = 9'(CHARGES);

   logic [MZ_LEN_W-1:0]  mz_len_ff;
   logic [CHG_LEN_W-1:0] charges_ff;

   logic             accept;
   logic             in_range;
   logic [18:0]      slot_full;
   logic [AW-1:0]    slot;
   logic [PROD_W-1:0] prod_in;

   logic              s1_valid_ff;
   logic              s1_req_ff;
   logic              s1_en_ff;
   logic              s1_hit_ff;
   logic              s1_last_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic [PROD_W-1:0] s1_prod_ff;

   logic             wr_last_valid_ff;
   logic [AW-1:0]    wr_last_addr_ff;
   logic [ACC_W-1:0] wr_last_data_ff;

   logic [CNT_W-1:0] dropped_ff, dropped_in;
   logic [CNT_W-1:0] peaks_ff, peaks_in;

   logic [ACC_W-1:0] mem_rd_data;
   logic             clr_busy;
   logic             fwd_hit;
   logic [ACC_W-1:0] cur_value;
   logic [ACC_W-1:0] add_value;
   logic [ACC_W:0]   sum_wide;
   logic [ACC_W-1:0] new_value;
   logic             is_read;
   logic             is_contrib;
   logic             mem_wr_en;
   logic [ACC_W-1:0] mem_wr_data;

   logic             s1_push;
   logic             rsp_pop;
   rsp_item_type     push_item;
   rsp_item_type     head_item;
   logic             fifo_valid;
   logic [1:0]       fifo_count;
   logic [2:0]       fill_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         mz_len_ff  <= MZ_LEN_RESET;
         charges_ff <= CHARGES_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MZ_LEN:  mz_len_ff  <= csr_wdata[MZ_LEN_W-1:0];
            CSR_CHARGES: charges_ff <= csr_wdata[CHG_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      in_range = ({1'b0, req_ch.target_mz_index} < mz_len_ff)
               && (17'(req_ch.target_mz_index) < MZ_BINS_LIM)
               && ({1'b0, req_ch.charge_index} < charges_ff)
               && (9'(req_ch.charge_index) < CHARGES_LIM);
      slot_full = 19'(req_ch.target_mz_index) * 19'(CHARGES_LIM)
                + 19'(req_ch.charge_index);
      slot      = AW'(slot_full);
      prod_in   = PROD_W'(req_ch.intensity) * PROD_W'(req_ch.weight);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff  <= req_ch.req_type;
         s1_en_ff   <= req_ch.source_enabled;
         s1_hit_ff  <= in_range;
         s1_last_ff <= req_ch.last_of_run;
         s1_addr_ff <= slot;
         s1_prod_ff <= prod_in;
      end
   end

   isc_acc_mem #(
      .DEPTH (DEPTH)
   ) u_acc_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (slot),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (mem_wr_data),
      .busy    (clr_busy)
   );

   // The write of the previous cycle lands at the same edge as this item's
   // read, so the memory word may be stale and the last write is forwarded.
   always_comb begin
      fwd_hit     = wr_last_valid_ff && (wr_last_addr_ff == s1_addr_ff);
      cur_value   = fwd_hit ? wr_last_data_ff : mem_rd_data;
      add_value   = ACC_W'(s1_prod_ff >> FRAC_BITS);
      sum_wide    = {1'b0, cur_value} + {1'b0, add_value};
      new_value   = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];
      is_read     = s1_valid_ff && (s1_req_ff == REQ_READ);
      is_contrib  = s1_valid_ff && (s1_req_ff == REQ_CONTRIBUTE) && s1_en_ff;
      mem_wr_en   = s1_hit_ff && (is_read || is_contrib);
      mem_wr_data = is_read ? '0 : new_value;

      dropped_in = dropped_ff;
      if (is_contrib && !s1_hit_ff && (dropped_ff != CNT_MAX)) begin
         dropped_in = dropped_ff + CNT_W'(1);
      end
      peaks_in = peaks_ff;
      if (is_contrib && s1_last_ff) begin
         peaks_in = peaks_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_last_valid_ff <= 1'b0;
         dropped_ff       <= '0;
         peaks_ff         <= '0;
      end else begin
         if (mem_wr_en) begin
            wr_last_valid_ff <= 1'b1;
         end
         dropped_ff <= dropped_in;
         peaks_ff   <= peaks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         wr_last_addr_ff <= s1_addr_ff;
         wr_last_data_ff <= mem_wr_data;
      end
   end

   always_comb begin
      s1_push                 = is_read;
      push_item.sum_value     = s1_hit_ff ? cur_value : '0;
      push_item.dropped_count = dropped_ff;
      push_item.peaks_done    = peaks_ff;
   end

   isc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_push),
      .push_data (push_item),
      .pop       (rsp_pop),
      .valid     (fifo_valid),
      .head      (head_item),
      .count     (fifo_count)
   );

   assign rsp_pop = fifo_valid && rsp_ch.ready;

   // A transaction taken now is pushed into the buffer in the next cycle, so the buffer
   // must have room for it after this cycle's push and pop.
   always_comb begin
      fill_after   = {1'b0, fifo_count} + 3'(s1_push);
      req_ch.ready = !clr_busy && (fill_after <= (3'd1 + 3'(rsp_pop)));
   end

   assign rsp_ch.valid         = fifo_valid;
   assign rsp_ch.sum_value     = head_item.sum_value;
   assign rsp_ch.dropped_count = head_item.dropped_count;
   assign rsp_ch.peaks_done    = head_item.peaks_done;

   `ISC_ASSERT_NOW(a_no_accept_in_clear, clock, reset, accept, !clr_busy)
   `ISC_ASSERT_NOW(a_buffer_room, clock, reset, s1_push, (fifo_count != 2'd2) || rsp_pop)
   `ISC_ASSERT_NEXT(a_drop_count_rises, clock, reset, 1'b1, dropped_ff >= $past(dropped_ff))
   `ISC_ASSERT_NEXT(a_stage_follows, clock, reset, accept, s1_valid_ff && (s1_addr_ff == $past(slot)))

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import isc_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 400;
   localparam int RANDOM_PHASES = 5;
   localparam int HOLD_CYCLES   = 400;
   localparam int DROP_BURST    = 24;
   localparam int HIT_BURST     = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   localparam logic [INT_W-1:0] INT_MAX = '1;
   localparam logic [WGT_W-1:0] WGT_MAX = '1;
   localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

   typedef struct packed {
      logic             req_type;
      logic             source_enabled;
      logic [INT_W-1:0] intensity;
      logic [WGT_W-1:0] weight;
      logic [MZ_W-1:0]  target_mz_index;
      logic [CH_W-1:0]  charge_index;
      logic             last_of_run;
   } isotope_entry_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   isc_req_if req_ch ();
   isc_rsp_if rsp_ch ();

   isotope_scatter_accumulate_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bit [ACC_W-1:0]     acc_shadow [MZ_BINS_DEF * CHARGES_DEF];
   bit [CNT_W-1:0]     dropped_shadow;
   bit [CNT_W-1:0]     peaks_shadow;
   bit [MZ_LEN_W-1:0]  mz_len_shadow  = MZ_LEN_RESET;
   bit [CHG_LEN_W-1:0] charges_shadow = CHARGES_RESET;
   rsp_item_type       pending_reads [$];

   int   mismatch_count = 0;
   int   req_idle_max   = 16;
   int   rsp_idle_max   = 16;
   logic rsp_hold       = 1'b0;

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                  input logic [ACC_W-1:0] want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic void predict_scatter(input isotope_entry_type e);
      int unsigned   mz_lim;
      int unsigned   ch_lim;
      int unsigned   slot;
      bit            in_use;
      bit [PROD_W-1:0] product;
      bit [ACC_W:0]  total;
      rsp_item_type  r;
      mz_lim = (mz_len_shadow < MZ_BINS_DEF) ? mz_len_shadow : MZ_BINS_DEF;
      ch_lim = (charges_shadow < CHARGES_DEF) ? charges_shadow : CHARGES_DEF;
      in_use = (e.target_mz_index < mz_lim) && (e.charge_index < ch_lim);
      slot   = e.target_mz_index * CHARGES_DEF + e.charge_index;
      if (e.req_type == REQ_READ) begin
         r.sum_value     = in_use ? acc_shadow[slot] : '0;
         r.dropped_count = dropped_shadow;
         r.peaks_done    = peaks_shadow;
         if (in_use) begin
            acc_shadow[slot] = '0;
         end
         pending_reads.push_back(r);
      end else if (e.source_enabled) begin
         if (in_use) begin
            product = e.intensity * e.weight;
            total = acc_shadow[slot] + (product >> FRAC_BITS);
            acc_shadow[slot] = total[ACC_W] ? ACC_MAX : total[ACC_W-1:0];
         end else if (dropped_shadow != CNT_MAX) begin
            dropped_shadow++;
         end
         if (e.last_of_run) begin
            peaks_shadow++;
         end
      end
   endfunction

   task automatic send_entry(input isotope_entry_type e);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.req_type        <= e.req_type;
      req_ch.source_enabled  <= e.source_enabled;
      req_ch.intensity       <= e.intensity;
      req_ch.weight          <= e.weight;
      req_ch.target_mz_index <= e.target_mz_index;
      req_ch.charge_index    <= e.charge_index;
      req_ch.last_of_run     <= e.last_of_run;
      req_ch.valid           <= 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_scatter(e);
   endtask

   task automatic contribute(input logic en, input logic [INT_W-1:0] intensity,
                             input logic [WGT_W-1:0] weight, input logic [MZ_W-1:0] mz,
                             input logic [CH_W-1:0] ch, input logic last);
      isotope_entry_type e;
      e = '{REQ_CONTRIBUTE, en, intensity, weight, mz, ch, last};
      send_entry(e);
   endtask

   // The fields a read ignores carry random values.
   task automatic read_entry(input logic [MZ_W-1:0] mz, input logic [CH_W-1:0] ch);
      isotope_entry_type e;
      e = '{REQ_READ, 1'($urandom), INT_W'($urandom), WGT_W'($urandom), mz, ch,
            1'($urandom)};
      send_entry(e);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MZ_LEN) begin
         mz_len_shadow = value[MZ_LEN_W-1:0];
      end else if (idx == CSR_CHARGES) begin
         charges_shadow = value[CHG_LEN_W-1:0];
      end
   endtask

   task automatic set_limits(input logic [CSR_DATA_W-1:0] mz_len,
                             input logic [CSR_DATA_W-1:0] charges);
      wait_drained();
      write_csr(CSR_MZ_LEN, mz_len);
      write_csr(CSR_CHARGES, charges);
   endtask

   function automatic int unsigned pick_index(input int unsigned limit,
                                              input int unsigned top);
      int unsigned edge_pick;
      edge_pick = limit + $urandom_range(0, 1);
      edge_pick = (edge_pick == 0) ? 0 : edge_pick - 1;
      if (edge_pick > top) begin
         edge_pick = top;
      end
      case ($urandom_range(0, 3)) inside
         0: return $urandom_range(0, top);
         [1:2]: return $urandom_range(0, 3);
         default: return edge_pick;
      endcase
   endfunction

   task automatic test_directed_corners();
      read_entry(0, 0);
      contribute(1'b1, INT_MAX, WGT_ONE, 0, 0, 1'b0);
      contribute(1'b1, INT_MAX, WGT_MAX, 0, 0, 1'b1);
      contribute(1'b0, INT_MAX, WGT_MAX, 0, 0, 1'b1);
      contribute(1'b1, '0, WGT_MAX, 1023, 31, 1'b0);
      contribute(1'b1, INT_MAX, 17'd1, 1023, 31, 1'b1);
      contribute(1'b1, INT_MAX, '0, 1023, 31, 1'b0);
      read_entry(0, 0);
      read_entry(0, 0);
      read_entry(1023, 31);
      req_idle_max = 0;
      repeat (3) contribute(1'b1, 24'd123456, 17'd40000, 5, 7, 1'b0);
      read_entry(5, 7);
      contribute(1'b1, 24'd99, WGT_ONE, 5, 7, 1'b1);
      read_entry(5, 7);
      req_idle_max = 16;
   endtask

   task automatic test_register_limits();
      set_limits(11'd1, 11'd1);
      contribute(1'b1, 24'd1000, WGT_ONE, 0, 0, 1'b0);
      contribute(1'b1, 24'd1000, WGT_ONE, 1, 0, 1'b0);
      contribute(1'b1, 24'd1000, WGT_ONE, 0, 1, 1'b1);
      read_entry(1, 0);
      read_entry(0, 1);
      contribute(1'b1, 24'd5000, WGT_ONE, 0, 0, 1'b1);
      set_limits(11'd0, 11'd32);
      contribute(1'b1, 24'd7, WGT_ONE, 0, 0, 1'b0);
      read_entry(0, 0);
      set_limits(11'd1024, 11'd0);
      contribute(1'b1, 24'd7, WGT_ONE, 0, 0, 1'b1);
      read_entry(0, 0);
      // Charges value is masked to six bits, which leaves 33.
      set_limits(11'h7FF, 11'h7E1);
      write_csr(CSR_UNMAPPED_LO, '0);
      write_csr(CSR_UNMAPPED_HI, '0);
      read_entry(0, 0);
      contribute(1'b1, INT_MAX, WGT_ONE, 1023, 31, 1'b1);
      read_entry(1023, 31);
   endtask

   task automatic test_random_traffic();
      isotope_entry_type e;
      int unsigned       corner;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_limits(MZ_LEN_RESET, CSR_DATA_W'(CHARGES_RESET));
            1: set_limits(11'd1, 11'd1);
            2: set_limits(11'd16, 11'd4);
            3: set_limits(11'h7FF, 11'h03F);
            default: set_limits(CSR_DATA_W'($urandom_range(1, 1024)),
                                CSR_DATA_W'($urandom_range(1, 32)));
         endcase
         req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
         rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
         for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++) begin
            corner = $urandom_range(0, 7);
            e.req_type        = ($urandom_range(0, 9) < 3) ? REQ_READ : REQ_CONTRIBUTE;
            e.source_enabled  = ($urandom_range(0, 7) != 0);
            e.intensity       = (corner == 0) ? '0 : (corner == 1) ? INT_MAX
                                : INT_W'($urandom);
            e.weight          = (corner == 2) ? '0 : (corner == 3) ? WGT_MAX
                                : (corner == 4) ? WGT_ONE
                                : WGT_W'($urandom_range(0, 65536));
            e.target_mz_index = MZ_W'(pick_index(mz_len_shadow, 1023));
            e.charge_index    = CH_W'(pick_index(charges_shadow, 31));
            e.last_of_run     = ($urandom_range(0, 2) == 0);
            send_entry(e);
         end
      end
      req_idle_max = 16;
      rsp_idle_max = 16;
   endtask

   // The receiver stops for a long stretch while reads keep coming, so the
   // result buffer fills and the block has to stall its input.
   task automatic test_backpressure();
      set_limits(MZ_LEN_RESET, CSR_DATA_W'(CHARGES_RESET));
      req_idle_max = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (int i = 0; i < 60; i++) begin
         if (i % 3 == 0) begin
            contribute(1'b1, INT_W'($urandom), WGT_ONE, MZ_W'($urandom_range(0, 3)), 0,
                       1'b1);
         end else begin
            read_entry(MZ_W'($urandom_range(0, 3)), 0);
         end
      end
      wait_drained();
      req_idle_max = 16;
   endtask

   // With no bins in use every enabled transaction is dropped and counted,
   // and each one still completes a peak.
   task automatic test_dropped_counting();
      set_limits(11'd0, 11'd5);
      req_idle_max = 0;
      rsp_idle_max = 0;
      for (int i = 0; i < DROP_BURST; i++) begin
         contribute(1'b1, INT_W'($urandom), WGT_W'($urandom), MZ_W'($urandom),
                    CH_W'($urandom), 1'b1);
      end
      read_entry(0, 0);
      set_limits(MZ_LEN_RESET, CSR_DATA_W'(CHARGES_RESET));
      read_entry(0, 0);
      req_idle_max = 16;
      rsp_idle_max = 16;
   endtask

   task automatic test_repeated_hits();
      set_limits(MZ_LEN_RESET, CSR_DATA_W'(CHARGES_RESET));
      req_idle_max = 0;
      for (int i = 0; i < HIT_BURST; i++) begin
         contribute(1'b1, INT_MAX, WGT_MAX, 1023, 31, 1'($urandom));
      end
      read_entry(1023, 31);
      read_entry(1023, 31);
      req_idle_max = 16;
   endtask

   initial begin : rsp_drain
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            stall = $urandom_range(0, rsp_idle_max);
         end else if (stall > 0) begin
            stall--;
         end
         rsp_ch.ready <= (stall == 0) && !rsp_hold;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("result with no read outstanding", rsp_ch.sum_value, '0);
         end else begin
            want = pending_reads.pop_front();
            if (rsp_ch.sum_value !== want.sum_value) begin
               report_mismatch("sum_value", rsp_ch.sum_value, want.sum_value);
            end
            if (rsp_ch.dropped_count !== want.dropped_count) begin
               report_mismatch("dropped_count", ACC_W'(rsp_ch.dropped_count),
                               ACC_W'(want.dropped_count));
            end
            if (rsp_ch.peaks_done !== want.peaks_done) begin
               report_mismatch("peaks_done", ACC_W'(rsp_ch.peaks_done),
                               ACC_W'(want.peaks_done));
            end
         end
      end
   end

   initial begin
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_index              <= CSR_MZ_LEN;
      csr_wdata              <= '0;
      req_ch.valid           <= 1'b0;
      req_ch.req_type        <= REQ_CONTRIBUTE;
      req_ch.source_enabled  <= 1'b0;
      req_ch.intensity       <= '0;
      req_ch.weight          <= '0;
      req_ch.target_mz_index <= '0;
      req_ch.charge_index    <= '0;
      req_ch.last_of_run     <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_register_limits();
      test_random_traffic();
      test_backpressure();
      test_dropped_counting();
      test_repeated_hits();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
